// ===== hdl/flmxh64_pkg.sv =====
// Shared constants, queue entry type and item class codes for the 64-bit multiply-xor hash.
package flmxh64_pkg;

    localparam logic [63:0] K_SEED  = 64'hbc4a78eb0e083fb5;
    localparam logic [63:0] K_LANE1 = 64'hc2d4f379500c363f;
    localparam logic [63:0] K_LANE2 = 64'ha696a85adffcf585;
    localparam logic [63:0] K_LANE3 = 64'hfcb5791894673fd3;
    localparam logic [63:0] K_LANE4 = 64'hb828e5548ad84c69;
    localparam logic [63:0] K_OFF1  = 64'hff43a9d0c1c914cd;
    localparam logic [63:0] K_OFF2  = 64'hf049ed58f79e6153;
    localparam logic [63:0] K_MIX   = 64'hed27a0e9f72a6d47;

    localparam int QUEUE_DEPTH_DEFAULT = 4;

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_LANE   = 2'd0;
    localparam t_kind KIND_SERIAL = 2'd1;
    localparam t_kind KIND_TAIL   = 2'd2;

    typedef struct packed {
        logic [63:0] data_word;
        logic [30:0] msg_length;
        logic [63:0] start_key;
        logic        first;
        logic        init_lanes;
        t_kind       kind;
        logic [1:0]  lane_idx;
        logic        fold;
        logic        zero_tail;
        logic        last;
    } t_entry;

endpackage

// ===== hdl/flmxh64_mul.sv =====
// Iterative 64x64 (low 64 bits) multiplier built on one 32x32 multiplier.
module flmxh64_mul (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_busy,
    output logic        o_done,
    output logic [63:0] o_res
);
    import flmxh64_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [1:0]  r_step;
    logic [63:0] r_a;
    logic [63:0] r_b;
    logic [63:0] r_prod;
    logic [63:0] r_res;
    logic [31:0] w_x;
    logic [31:0] w_y;
    logic [63:0] w_prod;

    always_comb begin
        case (r_step)
            2'd0: begin
                w_x = r_a[31:0];
                w_y = r_b[31:0];
            end
            2'd1: begin
                w_x = r_a[31:0];
                w_y = r_b[63:32];
            end
            2'd2: begin
                w_x = r_a[63:32];
                w_y = r_b[31:0];
            end
            default: begin
                w_x = r_a[31:0];
                w_y = r_b[31:0];
            end
        endcase
    end

    assign w_prod = w_x * w_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= 2'd0;
        end else begin
            r_done <= !i_start && r_busy && (r_step == 2'd3);
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= 2'd0;
            end else if (r_busy) begin
                r_step <= r_step + 2'd1;
                if (r_step == 2'd3) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
        end else if (r_busy) begin
            r_prod <= w_prod;
            case (r_step)
                2'd0:    r_res <= r_res;
                2'd1:    r_res <= r_prod;
                default: r_res[63:32] <= r_res[63:32] + r_prod[31:0];
            endcase
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_res  = r_res;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("multiply started while busy");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy) && !r_busy)
        else $error("multiply done without a run");
    a_step_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy && r_step == 2'd0)
        else $error("multiply did not restart at step zero");

endmodule

// ===== hdl/flmxh64_back.sv =====
// Back end: sequences lane updates and serial mixing per queued word, and the final scramble per message.
module flmxh64_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_empty,
    input  flmxh64_pkg::t_entry  i_entry,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [63:0]          o_hash
);
    import flmxh64_pkg::*;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_START    = 4'd1;
    localparam logic [3:0] ST_START_W  = 4'd2;
    localparam logic [3:0] ST_DISPATCH = 4'd3;
    localparam logic [3:0] ST_LANE_W   = 4'd4;
    localparam logic [3:0] ST_FOLD     = 4'd5;
    localparam logic [3:0] ST_ABS1_W   = 4'd6;
    localparam logic [3:0] ST_ABS2     = 4'd7;
    localparam logic [3:0] ST_ABS2_W   = 4'd8;
    localparam logic [3:0] ST_END      = 4'd9;
    localparam logic [3:0] ST_FIN_W    = 4'd10;
    localparam logic [3:0] ST_OUT      = 4'd11;

    function automatic logic [63:0] xs23(input logic [63:0] v);
        xs23 = v ^ (v >> 23);
    endfunction

    function automatic logic [63:0] xs47(input logic [63:0] v);
        xs47 = v ^ (v >> 47);
    endfunction

    function automatic logic [63:0] lane_mul(input logic [1:0] idx);
        case (idx)
            2'd0:    lane_mul = K_LANE1;
            2'd1:    lane_mul = K_LANE2;
            2'd2:    lane_mul = K_LANE3;
            default: lane_mul = K_LANE4;
        endcase
    endfunction

    function automatic logic [63:0] rotr(input logic [63:0] v, input int d);
        rotr = (v >> d) | (v << (64 - d));
    endfunction

    logic [3:0]  r_state;
    t_entry      r_ent;
    logic        r_tail_pend;
    logic [63:0] r_k;
    logic [63:0] r_acc;
    logic [63:0] r_lane [4];
    logic [63:0] r_fin;
    logic        r_out_valid;
    logic [63:0] r_hash;

    logic        m_start;
    logic [63:0] m_a;
    logic [63:0] m_b;
    logic        m_busy;
    logic        m_done;
    logic [63:0] m_res;
    logic [63:0] w_start;

    flmxh64_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (m_start),
        .i_a     (m_a),
        .i_b     (m_b),
        .o_busy  (m_busy),
        .o_done  (m_done),
        .o_res   (m_res)
    );

    assign w_start = r_ent.start_key ^ m_res;
    assign o_pop   = (r_state == ST_IDLE) && !i_empty;

    always_comb begin
        m_start = 1'b0;
        m_a     = 64'd0;
        m_b     = 64'd0;
        case (r_state)
            ST_START: begin
                m_start = 1'b1;
                m_a     = {33'd0, r_ent.msg_length};
                m_b     = K_LANE1;
            end
            ST_DISPATCH: begin
                m_start = 1'b1;
                if (r_ent.kind == KIND_LANE) begin
                    m_a = r_lane[r_ent.lane_idx] ^ xs47(xs23(r_ent.data_word));
                    m_b = lane_mul(r_ent.lane_idx);
                end else begin
                    m_a = xs23(r_ent.data_word);
                    m_b = K_MIX;
                end
            end
            ST_ABS2: begin
                m_start = 1'b1;
                m_a     = r_acc;
                m_b     = r_k;
            end
            ST_END: begin
                if (r_tail_pend) begin
                    m_start = 1'b1;
                    m_a     = 64'd0;
                    m_b     = K_MIX;
                end else if (r_ent.last) begin
                    m_start = 1'b1;
                    m_a     = xs23(r_acc);
                    m_b     = K_MIX;
                end
            end
            default: begin
                m_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_tail_pend <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && r_state != ST_OUT) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (!i_empty) begin
                        r_tail_pend <= i_entry.zero_tail;
                        r_state     <= i_entry.first ? ST_START : ST_DISPATCH;
                    end
                end
                ST_START: r_state <= ST_START_W;
                ST_START_W: begin
                    if (m_done) r_state <= ST_DISPATCH;
                end
                ST_DISPATCH: begin
                    r_state <= (r_ent.kind == KIND_LANE) ? ST_LANE_W : ST_ABS1_W;
                end
                ST_LANE_W: begin
                    if (m_done) r_state <= r_ent.fold ? ST_FOLD : ST_END;
                end
                ST_FOLD: r_state <= ST_END;
                ST_ABS1_W: begin
                    if (m_done) r_state <= ST_ABS2;
                end
                ST_ABS2: r_state <= ST_ABS2_W;
                ST_ABS2_W: begin
                    if (m_done) r_state <= ST_END;
                end
                ST_END: begin
                    if (r_tail_pend) begin
                        r_tail_pend <= 1'b0;
                        r_state     <= ST_ABS1_W;
                    end else if (r_ent.last) begin
                        r_state <= ST_FIN_W;
                    end else begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_FIN_W: begin
                    if (m_done) r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (!i_empty) r_ent <= i_entry;
            end
            ST_START_W: begin
                if (m_done) begin
                    r_acc <= w_start;
                    if (r_ent.init_lanes) begin
                        r_lane[0] <= w_start + K_OFF1 + K_OFF2;
                        r_lane[1] <= w_start + K_OFF1;
                        r_lane[2] <= w_start;
                        r_lane[3] <= w_start - K_OFF2;
                    end
                end
            end
            ST_DISPATCH: begin
                r_k <= (r_ent.kind == KIND_SERIAL) ? K_LANE1 : K_LANE4;
            end
            ST_LANE_W: begin
                if (m_done) r_lane[r_ent.lane_idx] <= m_res;
            end
            ST_FOLD: begin
                r_acc <= rotr(r_lane[0], 1) ^ rotr(r_lane[1], 3)
                       ^ rotr(r_lane[2], 6) ^ rotr(r_lane[3], 11);
            end
            ST_ABS1_W: begin
                if (m_done) r_acc <= r_acc ^ xs47(m_res);
            end
            ST_ABS2_W: begin
                if (m_done) r_acc <= m_res;
            end
            ST_END: begin
                if (r_tail_pend) r_k <= K_LANE4;
            end
            ST_FIN_W: begin
                if (m_done) r_fin <= xs47(m_res);
            end
            ST_OUT: begin
                if (!r_out_valid || !i_out_stall) r_hash <= r_fin;
            end
            default: r_k <= r_k;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_hash      = r_hash;

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_done |-> (r_state == ST_START_W || r_state == ST_LANE_W || r_state == ST_ABS1_W
                    || r_state == ST_ABS2_W || r_state == ST_FIN_W))
        else $error("product returned outside a wait state");
    a_tail_before_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN_W) |-> !r_tail_pend)
        else $error("final scramble began with zero tail pending");
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && !(r_out_valid && i_out_stall)) |=>
            r_out_valid && r_state == ST_IDLE)
        else $error("finished hash not moved to output register");
    a_launch_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_start |-> !m_busy)
        else $error("multiplier launched while busy");

endmodule

// ===== hdl/flmxh64_queue.sv =====
// Small FIFO of classified words between the front and back ends.
module flmxh64_queue #(
    parameter int DEPTH = flmxh64_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  flmxh64_pkg::t_entry i_entry,
    output logic                o_full,
    input  logic                i_pop,
    output flmxh64_pkg::t_entry o_entry,
    output logic                o_empty
);
    import flmxh64_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_entry;
    end

    assign o_entry = r_mem[r_rd_ptr];
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);

endmodule

// ===== hdl/flmxh64_front.sv =====
// Front end: seed register, word position tracking and per-word classification.
module flmxh64_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_seed_we,
    input  logic [31:0]         i_seed,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [63:0]         i_data_word,
    input  logic [30:0]         i_msg_length,
    input  logic                i_full,
    output logic                o_push,
    output flmxh64_pkg::t_entry o_entry
);
    import flmxh64_pkg::*;

    logic [31:0] r_seed;
    logic [28:0] r_word_index;
    logic [30:0] r_held_length;

    logic        w_first;
    logic [30:0] w_len;
    logic [2:0]  w_rem;
    logic [28:0] w_n_lane;
    logic [28:0] w_n_full;
    logic [28:0] w_n_sum;
    logic [28:0] w_n_total;
    logic [29:0] w_next;
    logic        w_is_lane;
    logic        w_in_full;
    logic        w_last;
    logic [63:0] w_mask;
    t_kind       w_kind;

    assign w_first   = (r_word_index == '0);
    assign w_len     = w_first ? i_msg_length : r_held_length;
    assign w_rem     = w_len[2:0];
    assign w_n_lane  = {1'b0, w_len[30:5], 2'b00};
    assign w_n_full  = {1'b0, w_len[30:3]};
    assign w_n_sum   = w_n_full + {28'd0, (w_rem != 3'd0)};
    assign w_n_total = (w_n_sum == '0) ? 29'd1 : w_n_sum;
    assign w_next    = {1'b0, r_word_index} + 30'd1;
    assign w_is_lane = r_word_index < w_n_lane;
    assign w_in_full = r_word_index < w_n_full;
    assign w_last    = w_next >= {1'b0, w_n_total};

    always_comb begin
        for (int b = 0; b < 8; b++) begin
            w_mask[8*b +: 8] = (3'(b) < w_rem) ? 8'hff : 8'h00;
        end
        if (w_is_lane) begin
            w_kind = KIND_LANE;
        end else if (w_in_full) begin
            w_kind = KIND_SERIAL;
        end else begin
            w_kind = KIND_TAIL;
        end
    end

    assign o_in_stall = i_full;
    assign o_push     = i_in_valid && !i_full;

    always_comb begin
        o_entry.data_word  = (w_kind == KIND_TAIL) ? (i_data_word & w_mask) : i_data_word;
        o_entry.msg_length = w_len;
        o_entry.start_key  = K_SEED ^ {r_seed, r_seed};
        o_entry.first      = w_first;
        o_entry.init_lanes = w_first && (w_len[30:5] != '0);
        o_entry.kind       = w_kind;
        o_entry.lane_idx   = r_word_index[1:0];
        o_entry.fold       = w_is_lane && (w_next == {1'b0, w_n_lane});
        o_entry.zero_tail  = w_last && w_in_full;
        o_entry.last       = w_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed        <= '0;
            r_word_index  <= '0;
            r_held_length <= '0;
        end else begin
            if (i_seed_we) r_seed <= i_seed;
            if (o_push) begin
                r_word_index <= w_last ? '0 : w_next[28:0];
                if (w_first) r_held_length <= i_msg_length;
            end
        end
    end

endmodule

// ===== hdl/four_lane_multiply_xor_hash64_top.sv =====
// Top level of the four-lane multiply-xor 64-bit message hash.
// Words are taken in at up to one per cycle into a small queue while it is not full, then
// worked one at a time. All multiplies share one 32x32 multiplier. A lane word needs one
// product (the word that ends the lane part also folds the lanes), any other word two; the
// first word of a message adds a product for the start value, a nonzero length that is a
// multiple of eight adds two for the zero tail, and the final hash adds one more.
module four_lane_multiply_xor_hash64_top #(
    parameter int QUEUE_DEPTH = flmxh64_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_seed_we,
    input  logic [31:0] i_seed,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [63:0] i_data_word,
    input  logic [30:0] i_msg_length,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_hash
);
    import flmxh64_pkg::*;

    logic   w_push;
    logic   w_full;
    logic   w_pop;
    logic   w_empty;
    t_entry w_push_entry;
    t_entry w_head_entry;

    flmxh64_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_seed_we    (i_seed_we),
        .i_seed       (i_seed),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_data_word  (i_data_word),
        .i_msg_length (i_msg_length),
        .i_full       (w_full),
        .o_push       (w_push),
        .o_entry      (w_push_entry)
    );

    flmxh64_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_entry (w_head_entry),
        .o_empty (w_empty)
    );

    flmxh64_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (w_empty),
        .i_entry     (w_head_entry),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_hash      (o_hash)
    );

endmodule

// ===== sim/flmxh64_hash_checker.sv =====
// Checker for the 64-bit multiply-xor hash: watches both channels, predicts each hash, compares.
module flmxh64_hash_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_seed_we,
    input  logic [31:0] i_seed,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [63:0] i_data_word,
    input  logic [30:0] i_msg_length,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [63:0] i_hash,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import flmxh64_pkg::*;

    logic [31:0] seed_copy = '0;
    logic [63:0] lane_acc [4];
    logic [63:0] serial_acc = '0;
    int unsigned word_pos = 0;
    logic [30:0] held_len = '0;
    logic [63:0] expected_hashes [$];

    function automatic logic [63:0] scramble64(input logic [63:0] v);
        logic [63:0] t;
        t = v ^ (v >> 23);
        t = t * K_MIX;
        t = t ^ (t >> 47);
        return t;
    endfunction

    function automatic logic [63:0] rotr64(input logic [63:0] v, input int unsigned d);
        return (v >> d) | (v << (64 - d));
    endfunction

    function automatic logic [63:0] lane_multiplier(input int unsigned idx);
        case (idx % 4)
            0: return K_LANE1;
            1: return K_LANE2;
            2: return K_LANE3;
            default: return K_LANE4;
        endcase
    endfunction

    function automatic void absorb_serial(input logic [63:0] w, input logic [63:0] mul);
        serial_acc = (serial_acc ^ scramble64(w)) * mul;
    endfunction

    // Advances the hash state by one word; returns 1 when the message completes.
    function automatic bit hash_step(input logic [63:0] word, input logic [30:0] length,
                                     output logic [63:0] digest);
        logic [63:0] start;
        logic [63:0] v;
        logic [63:0] mask;
        int unsigned len_u;
        int unsigned rem;
        int unsigned n_lane;
        int unsigned n_full;
        int unsigned n_total;
        int unsigned idx;
        digest = '0;
        if (word_pos == 0) begin
            held_len = length;
            start = K_SEED ^ {seed_copy, seed_copy} ^ (64'(length) * K_LANE1);
            if (length >= 31'd32) begin
                lane_acc[2] = start;
                lane_acc[1] = start + K_OFF1;
                lane_acc[0] = lane_acc[1] + K_OFF2;
                lane_acc[3] = start - K_OFF2;
            end
            serial_acc = start;
        end
        len_u = 32'(held_len);
        idx = word_pos;
        rem = len_u & 7;
        n_lane = (len_u >> 5) << 2;
        n_full = len_u >> 3;
        n_total = n_full + ((rem != 0) ? 1 : 0);
        if (n_total == 0) n_total = 1;

        if (idx < n_lane) begin
            v = word ^ (word >> 23);
            v = v ^ (v >> 47);
            lane_acc[idx % 4] = (lane_acc[idx % 4] ^ v) * lane_multiplier(idx);
            if (idx + 1 == n_lane) begin
                serial_acc = rotr64(lane_acc[0], 1) ^ rotr64(lane_acc[1], 3)
                           ^ rotr64(lane_acc[2], 6) ^ rotr64(lane_acc[3], 11);
            end
        end else if (idx < n_full) begin
            absorb_serial(word, K_LANE1);
        end else begin
            mask = (rem != 0) ? ((64'd1 << (8 * rem)) - 64'd1) : 64'd0;
            absorb_serial(word & mask, K_LANE4);
        end

        if (idx + 1 >= n_total) begin
            if (idx < n_full) absorb_serial(64'd0, K_LANE4);
            digest = scramble64(serial_acc);
            word_pos = 0;
            return 1'b1;
        end
        word_pos = (idx + 1) & 32'h1fff_ffff;
        return 1'b0;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] exp_val,
                                   input logic [63:0] got_val);
        $display("ERROR %0t: %s: expected %h, got %h", $time, what, exp_val, got_val);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin : watch
        logic [63:0] digest;
        logic [63:0] exp_hash;
        if (!i_rst_n) begin
            seed_copy = '0;
            for (int k = 0; k < 4; k++) lane_acc[k] = '0;
            serial_acc = '0;
            word_pos = 0;
            held_len = '0;
            expected_hashes.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_hashes.size() == 0) begin
                    report_mismatch("hash transfer with no message pending", '0, i_hash);
                end else begin
                    exp_hash = expected_hashes.pop_front();
                    if (i_hash !== exp_hash) report_mismatch("hash", exp_hash, i_hash);
                end
            end
            if (i_seed_we) seed_copy = i_seed;
            if (i_in_valid && !i_in_stall) begin
                if (hash_step(i_data_word, i_msg_length, digest))
                    expected_hashes.push_back(digest);
            end
        end
        o_pending = expected_hashes.size();
    end

endmodule

// ===== sim/four_lane_multiply_xor_hash64_top_test.sv =====
// Testbench top for the 64-bit multiply-xor hash: clock, reset, stimulus and verdict.
module four_lane_multiply_xor_hash64_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import flmxh64_pkg::*;

    localparam int RESET_CYCLES    = 12;
    localparam int SETTLE_CYCLES   = 100;
    localparam int STALL_LIMIT     = 5000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int PHASE_WORDS     = 64;
    localparam int PHASE_COUNT     = 6;

    typedef enum {PACE_SENDER_IDLE, PACE_RECEIVER_IDLE, PACE_NO_IDLE} t_pace;
    typedef enum {FILL_RANDOM, FILL_ONES, FILL_ZERO} t_fill;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        seed_we = 1'b0;
    logic [31:0] seed = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [63:0] data_word = '0;
    logic [30:0] msg_length = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [63:0] hash;
    int          fail_count;
    int          pending;

    t_pace pace = PACE_SENDER_IDLE;
    bit    hold_request = 1'b0;
    int    hold_left = 0;
    int    quiet_cycles = 0;
    int    words_sent = 0;

    four_lane_multiply_xor_hash64_top u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_seed_we   (seed_we),
        .i_seed      (seed),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_data_word (data_word),
        .i_msg_length(msg_length),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_hash      (hash)
    );

    flmxh64_hash_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_seed_we   (seed_we),
        .i_seed      (seed),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_data_word (data_word),
        .i_msg_length(msg_length),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_hash      (hash),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    function automatic int sender_idle_pct(input t_pace m);
        case (m)
            PACE_SENDER_IDLE:   return 11;
            PACE_RECEIVER_IDLE: return 47;
            default:            return 0;
        endcase
    endfunction

    function automatic int receiver_stall_pct(input t_pace m);
        case (m)
            PACE_SENDER_IDLE:   return 47;
            PACE_RECEIVER_IDLE: return 11;
            default:            return 0;
        endcase
    endfunction

    // Receiver side; a hold-off request stalls the output for a long stretch.
    initial begin
        forever begin
            @(negedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(99) < receiver_stall_pct(pace));
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_word(input logic [63:0] word, input logic [30:0] length);
        while ($urandom_range(99) < sender_idle_pct(pace)) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        data_word <= word;
        msg_length <= length;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        words_sent++;
    endtask

    // Later words carry random length fields; only the first one counts.
    task automatic send_message(input int unsigned length, input t_fill fill);
        int unsigned n_words;
        logic [63:0] word;
        logic [30:0] len_field;
        n_words = (length + 7) / 8;
        if (n_words == 0) n_words = 1;
        for (int unsigned k = 0; k < n_words; k++) begin
            case (fill)
                FILL_ONES: word = '1;
                FILL_ZERO: word = '0;
                default:   word = {$urandom, $urandom};
            endcase
            len_field = (k == 0) ? 31'(length) : 31'($urandom);
            send_word(word, len_field);
        end
    endtask

    task automatic write_seed(input logic [31:0] value);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        seed_we <= 1'b1;
        seed <= value;
        @(negedge clk);
        seed_we <= 1'b0;
    endtask

    function automatic int unsigned random_length();
        int unsigned r;
        int unsigned len;
        r = $urandom_range(99);
        if (r < 50)      len = $urandom_range(40, 0);
        else if (r < 80) len = $urandom_range(100, 41);
        else if (r < 95) len = $urandom_range(200, 101);
        else             len = $urandom_range(400, 201);
        if ($urandom_range(3) == 0) len = len & ~32'd7;
        return len;
    endfunction

    function automatic t_fill random_fill();
        case ($urandom_range(15))
            0:       return FILL_ONES;
            1:       return FILL_ZERO;
            default: return FILL_RANDOM;
        endcase
    endfunction

    function automatic logic [31:0] phase_seed(input int p);
        case (p)
            0, 5:    return 32'hffff_ffff;
            2:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty messages, partial words with junk in the unused bytes,
        // exact multiples of eight, lane-only, lane plus tail, lane plus serial
        send_message(0, FILL_RANDOM);
        send_message(0, FILL_ONES);
        send_message(1, FILL_ONES);
        send_message(7, FILL_ONES);
        send_message(8, FILL_RANDOM);
        send_message(15, FILL_ONES);
        send_message(32, FILL_RANDOM);
        send_message(33, FILL_ONES);
        send_message(40, FILL_ZERO);

        for (int p = 0; p < PHASE_COUNT; p++) begin
            pace = t_pace'(p / 2);
            write_seed(phase_seed(p));
            if (p == 4) hold_request = 1'b1;
            words_sent = 0;
            while (words_sent < PHASE_WORDS) send_message(random_length(), random_fill());
        end

        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
